/* src/assert_macros.svh */
// assertion helpers for the bound assertion checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with reset disable
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// clocked assertion that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

/* src/hrpc_pkg.sv */
`default_nettype none
package hrpc_pkg;

  localparam int DEF_MAX_FRAME_PIXELS = 1048576;
  localparam int DEF_QUEUE_DEPTH      = 4;
  localparam int RATIO_W              = 17;
  localparam int TOTAL_W              = 21;
  localparam int ADDR_W               = 5;

  localparam logic [2:0] REG_LO_MIN  = 3'd0;
  localparam logic [2:0] REG_LO_MAX  = 3'd1;
  localparam logic [2:0] REG_HI_MIN  = 3'd2;
  localparam logic [2:0] REG_HI_MAX  = 3'd3;
  localparam logic [2:0] REG_SAT_MIN = 3'd4;
  localparam logic [2:0] REG_VAL_MIN = 3'd5;
  localparam logic [2:0] REG_GAIN    = 3'd6;

  typedef struct packed {
    logic [7:0] lo_min;
    logic [7:0] lo_max;
    logic [7:0] hi_min;
    logic [7:0] hi_max;
    logic [7:0] sat_min;
    logic [7:0] val_min;
    logic [8:0] gain;
  } hrpc_cfg_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       mark;
    logic       last;
  } hrpc_pix_t;

endpackage
`default_nettype wire

/* src/hrpc_queue.sv */
`default_nettype none
module hrpc_queue
  import hrpc_pkg::*;
#(
  parameter int DATA_W = 8,
  parameter int DEPTH  = DEF_QUEUE_DEPTH
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire logic [DATA_W-1:0] data_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   valid_o,
  output logic      [DATA_W-1:0] data_o
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_P = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_C = CNT_W'(DEPTH);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_q, rd_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == FULL_C);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LAST_P) ? '0 : wr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == LAST_P) ? '0 : rd_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end
endmodule
`default_nettype wire

/* src/hrpc_front.sv */
`default_nettype none
module hrpc_front
  import hrpc_pkg::*;
#(
  parameter int MAX_FRAME_PIXELS = DEF_MAX_FRAME_PIXELS,
  parameter int CNT_W = $clog2(MAX_FRAME_PIXELS + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire hrpc_cfg_t        cfg_i,
  input  wire logic             take_i,
  input  wire logic [7:0]       blue_i,
  input  wire logic [7:0]       green_i,
  input  wire logic [7:0]       red_i,
  input  wire logic             last_i,
  output hrpc_pix_t             pix_o,
  output logic      [CNT_W-1:0] pix_cnt_o,
  output logic      [CNT_W-1:0] mark_cnt_o
);
  localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_FRAME_PIXELS);

  // rounded reciprocal tables, 12 fraction bits
  logic [19:0] sdiv_tab [256];
  logic [16:0] hdiv_tab [256];
  assign sdiv_tab[0] = '0;
  assign hdiv_tab[0] = '0;
  for (genvar i = 1; i < 256; i++) begin : g_tab
    localparam logic [19:0] SD = 20'((1044480 + i / 2) / i);
    localparam logic [16:0] HD = 17'((122880 + i / 2) / i);
    assign sdiv_tab[i] = SD;
    assign hdiv_tab[i] = HD;
  end

  logic [7:0]         mx, mn, diff, hue, sat;
  logic [27:0]        s_prod;
  logic signed [11:0] num, nb, ng, nr, nd;
  logic signed [28:0] h_prod;
  logic signed [31:0] t;
  logic signed [9:0]  hv;
  logic               band1, band2, mark;
  logic [CNT_W-1:0]   pix_q, mark_q, pix_n, mark_n;

  always_comb begin
    mx = red_i;
    mn = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx) mx = blue_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
    diff = mx - mn;
    s_prod = 28'(diff) * 28'(sdiv_tab[mx]) + 28'd2048;
    sat = 8'(s_prod >> 12);
    nb = $signed({4'b0000, blue_i});
    ng = $signed({4'b0000, green_i});
    nr = $signed({4'b0000, red_i});
    nd = $signed({4'b0000, diff});
    if (mx == red_i) begin
      num = ng - nb;
    end else if (mx == green_i) begin
      num = nb - nr + (nd <<< 1);
    end else begin
      num = nr - ng + (nd <<< 2);
    end
    h_prod = 29'(num) * $signed({12'b0, hdiv_tab[diff]});
    t = 32'(h_prod) + 32'sd2048 + 32'sd1048576;
    hv = $signed({1'b0, t[20:12]}) - 10'sd256;
    if (diff == 8'd0) begin
      hue = 8'd0;
    end else if (hv < 0) begin
      hue = 8'(hv + 10'sd180);
    end else begin
      hue = 8'(hv);
    end
    band1 = (hue >= cfg_i.lo_min) && (hue <= cfg_i.lo_max);
    band2 = (hue >= cfg_i.hi_min) && (hue <= cfg_i.hi_max);
    mark  = (band1 || band2) && (sat >= cfg_i.sat_min) && (mx >= cfg_i.val_min);
    pix_n  = (pix_q < MAX_C) ? pix_q + CNT_W'(1) : pix_q;
    mark_n = (mark && (mark_q < MAX_C)) ? mark_q + CNT_W'(1) : mark_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_q  <= '0;
      mark_q <= '0;
    end else if (take_i) begin
      pix_q  <= last_i ? '0 : pix_n;
      mark_q <= last_i ? '0 : mark_n;
    end
  end

  assign pix_o.blue  = blue_i;
  assign pix_o.green = green_i;
  assign pix_o.red   = red_i;
  assign pix_o.mark  = mark;
  assign pix_o.last  = last_i;
  assign pix_cnt_o   = pix_n;
  assign mark_cnt_o  = mark_n;
endmodule
`default_nettype wire

/* src/hrpc_back.sv */
`default_nettype none
module hrpc_back
  import hrpc_pkg::*;
#(
  parameter int CNT_W = 21
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [8:0]         gain_i,
  input  wire logic               q_valid_i,
  input  wire hrpc_pix_t          q_pix_i,
  input  wire logic [CNT_W-1:0]   q_pix_cnt_i,
  input  wire logic [CNT_W-1:0]   q_mark_cnt_i,
  output logic                    q_pop_o,
  output logic                    empty_o,
  input  wire logic               pop_i,
  output logic      [7:0]         blue_o,
  output logic      [7:0]         green_o,
  output logic      [7:0]         red_o,
  output logic                    marked_o,
  output logic                    frame_end_o,
  output logic      [RATIO_W-1:0] ratio_o,
  output logic      [TOTAL_W-1:0] total_o
);
  localparam int STEP_W = $clog2(RATIO_W);

  function automatic logic [7:0] dim(input logic [7:0] c, input logic [8:0] g);
    logic [17:0] p;
    p = 18'(c) * 18'(g) + 18'd128;
    return (p[17:16] != 2'b00) ? 8'hff : p[15:8];
  endfunction

  logic              out_valid_q, busy_q, take;
  logic [STEP_W-1:0] step_q;
  logic [CNT_W:0]    rem_q, rem_sub, rem_n;
  logic [CNT_W-1:0]  div_q;
  logic [RATIO_W-1:0] quo_q;
  logic              ge;

  assign take    = !busy_q && q_valid_i && (!out_valid_q || pop_i);
  assign q_pop_o = take;
  assign empty_o = !out_valid_q;

  // restoring division, one quotient bit per cycle
  assign ge      = rem_q >= {1'b0, div_q};
  assign rem_sub = rem_q - {1'b0, div_q};
  assign rem_n   = ge ? rem_sub : rem_q;

  always_ff @(posedge clk_i) begin
    if (take) begin
      blue_o      <= q_pix_i.mark ? q_pix_i.blue  : dim(q_pix_i.blue, gain_i);
      green_o     <= q_pix_i.mark ? q_pix_i.green : dim(q_pix_i.green, gain_i);
      red_o       <= q_pix_i.mark ? q_pix_i.red   : dim(q_pix_i.red, gain_i);
      marked_o    <= q_pix_i.mark;
      frame_end_o <= q_pix_i.last;
      total_o     <= q_pix_i.last ? TOTAL_W'(q_mark_cnt_i) : '0;
      ratio_o     <= '0;
      rem_q       <= {1'b0, q_mark_cnt_i};
      div_q       <= q_pix_cnt_i;
      quo_q       <= '0;
    end else if (busy_q) begin
      rem_q <= {rem_n[CNT_W-1:0], 1'b0};
      quo_q <= {quo_q[RATIO_W-2:0], ge};
      if (step_q == '0) begin
        ratio_o <= {quo_q[RATIO_W-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      busy_q      <= 1'b0;
      step_q      <= '0;
    end else if (take) begin
      busy_q      <= q_pix_i.last;
      out_valid_q <= !q_pix_i.last;
      step_q      <= STEP_W'(RATIO_W - 1);
    end else if (busy_q) begin
      step_q <= step_q - STEP_W'(1);
      if (step_q == '0) begin
        busy_q      <= 1'b0;
        out_valid_q <= 1'b1;
      end
    end else if (pop_i && out_valid_q) begin
      out_valid_q <= 1'b0;
    end
  end
endmodule
`default_nettype wire

/* src/hsv_red_pixel_counter_unit.sv */
// a pixel goes through the queue and the result register; the last pixel of a frame holds the
// back end while the ratio divider produces one quotient bit per cycle
// throughput: one pixel per cycle while the queue has room and results are popped
// a 4-entry queue (default depth) between classifier and output stage buffers pixels until full
// reset: counters cleared, registers at their defaults, queue and output empty
`default_nettype none
module hsv_red_pixel_counter_unit
  import hrpc_pkg::*;
#(
  parameter int MAX_FRAME_PIXELS = DEF_MAX_FRAME_PIXELS,
  parameter int QUEUE_DEPTH      = DEF_QUEUE_DEPTH
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // pixel side
  input  wire logic               push,
  output logic                    full,
  input  wire logic [7:0]         blue_i,
  input  wire logic [7:0]         green_i,
  input  wire logic [7:0]         red_i,
  input  wire logic               last_pixel_i,
  // result side
  output logic                    empty,
  input  wire logic               pop,
  output logic      [7:0]         out_blue_o,
  output logic      [7:0]         out_green_o,
  output logic      [7:0]         out_red_o,
  output logic                    marked_o,
  output logic                    frame_end_o,
  output logic      [RATIO_W-1:0] marked_ratio_o,
  output logic      [TOTAL_W-1:0] marked_total_o,
  // register port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [ADDR_W-1:0]  paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);
  // counters just wide enough for the saturation limit
  localparam int CNT_W  = $clog2(MAX_FRAME_PIXELS + 1);
  localparam int DATA_W = $bits(hrpc_pix_t) + 2 * CNT_W;

  hrpc_cfg_t        cfg_q;
  logic [2:0]       reg_idx;
  logic             wr_en;
  logic             take;
  hrpc_pix_t        f_pix, q_pix;
  logic [CNT_W-1:0] f_pix_cnt, f_mark_cnt, q_pix_cnt, q_mark_cnt;
  logic [DATA_W-1:0] q_wdata, q_rdata;
  logic             q_valid, q_pop;

  // register file, written on the apb access phase
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lo_min  <= 8'd0;
      cfg_q.lo_max  <= 8'd20;
      cfg_q.hi_min  <= 8'd160;
      cfg_q.hi_max  <= 8'd180;
      cfg_q.sat_min <= 8'd70;
      cfg_q.val_min <= 8'd50;
      cfg_q.gain    <= 9'd77;
    end else if (wr_en) begin
      case (reg_idx)
        REG_LO_MIN:  cfg_q.lo_min  <= pwdata[7:0];
        REG_LO_MAX:  cfg_q.lo_max  <= pwdata[7:0];
        REG_HI_MIN:  cfg_q.hi_min  <= pwdata[7:0];
        REG_HI_MAX:  cfg_q.hi_max  <= pwdata[7:0];
        REG_SAT_MIN: cfg_q.sat_min <= pwdata[7:0];
        REG_VAL_MIN: cfg_q.val_min <= pwdata[7:0];
        REG_GAIN:    cfg_q.gain    <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_LO_MIN:  prdata = {24'b0, cfg_q.lo_min};
      REG_LO_MAX:  prdata = {24'b0, cfg_q.lo_max};
      REG_HI_MIN:  prdata = {24'b0, cfg_q.hi_min};
      REG_HI_MAX:  prdata = {24'b0, cfg_q.hi_max};
      REG_SAT_MIN: prdata = {24'b0, cfg_q.sat_min};
      REG_VAL_MIN: prdata = {24'b0, cfg_q.val_min};
      REG_GAIN:    prdata = {23'b0, cfg_q.gain};
      default:     prdata = '0;
    endcase
  end

  // pixel accepted when the queue has room
  assign take = push && !full;

  // front end: hsv conversion, band test and frame counters
  hrpc_front #(
    .MAX_FRAME_PIXELS(MAX_FRAME_PIXELS),
    .CNT_W(CNT_W)
  ) u_front (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_i(cfg_q),
    .take_i(take),
    .blue_i(blue_i),
    .green_i(green_i),
    .red_i(red_i),
    .last_i(last_pixel_i),
    .pix_o(f_pix),
    .pix_cnt_o(f_pix_cnt),
    .mark_cnt_o(f_mark_cnt)
  );

  // classified pixels wait here while the back end divides
  assign q_wdata = {f_pix, f_pix_cnt, f_mark_cnt};
  assign {q_pix, q_pix_cnt, q_mark_cnt} = q_rdata;

  hrpc_queue #(
    .DATA_W(DATA_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .data_i(q_wdata),
    .full_o(full),
    .pop_i(q_pop),
    .valid_o(q_valid),
    .data_o(q_rdata)
  );

  // back end: dimming, ratio divider and result register
  hrpc_back #(
    .CNT_W(CNT_W)
  ) u_back (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .gain_i(cfg_q.gain),
    .q_valid_i(q_valid),
    .q_pix_i(q_pix),
    .q_pix_cnt_i(q_pix_cnt),
    .q_mark_cnt_i(q_mark_cnt),
    .q_pop_o(q_pop),
    .empty_o(empty),
    .pop_i(pop),
    .blue_o(out_blue_o),
    .green_o(out_green_o),
    .red_o(out_red_o),
    .marked_o(marked_o),
    .frame_end_o(frame_end_o),
    .ratio_o(marked_ratio_o),
    .total_o(marked_total_o)
  );
endmodule
`default_nettype wire

/* src/hrpc_checker.sv */
`default_nettype none
`include "assert_macros.svh"
module hrpc_assert_checker
  import hrpc_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               empty,
  input wire logic               pop,
  input wire logic               pready,
  input wire logic [7:0]         out_blue_o,
  input wire logic               frame_end_o,
  input wire logic [RATIO_W-1:0] marked_ratio_o,
  input wire logic [TOTAL_W-1:0] marked_total_o
);
  `ASSERT_ALWAYS(a_pready_high, clk_i, pready)
  `ASSERT_CLK(a_stats_zero_midframe, clk_i, rst_ni, (!empty && !frame_end_o) |-> (marked_ratio_o == '0 && marked_total_o == '0))
  `ASSERT_CLK(a_ratio_bound, clk_i, rst_ni, (!empty && frame_end_o) |-> (marked_ratio_o <= RATIO_W'(65536)))
  `ASSERT_CLK(a_result_holds, clk_i, rst_ni, (!empty && !pop) |=> (!empty && $stable(out_blue_o)))
endmodule

bind hsv_red_pixel_counter_unit hrpc_assert_checker u_chk (.*);
`default_nettype wire

/* sim/hrpc_checker.sv */
module hrpc_checker
  import hrpc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  input  logic               full,
  input  logic [7:0]         blue_i,
  input  logic [7:0]         green_i,
  input  logic [7:0]         red_i,
  input  logic               last_pixel_i,
  input  logic               empty,
  input  logic               pop,
  input  logic [7:0]         out_blue_o,
  input  logic [7:0]         out_green_o,
  input  logic [7:0]         out_red_o,
  input  logic               marked_o,
  input  logic               frame_end_o,
  input  logic [RATIO_W-1:0] marked_ratio_o,
  input  logic [TOTAL_W-1:0] marked_total_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output int                 fail_count,
  output int                 pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_CAP = DEF_MAX_FRAME_PIXELS;

  typedef struct packed {
    logic [7:0]         blue;
    logic [7:0]         green;
    logic [7:0]         red;
    logic               mark;
    logic               last;
    logic [RATIO_W-1:0] ratio;
    logic [TOTAL_W-1:0] total;
  } pixel_result_t;

  hrpc_cfg_t       cfg;
  int unsigned     pix_cnt, mark_cnt;
  pixel_result_t   expected_pixels[$];

  assign pending_count = expected_pixels.size();

  function automatic logic [7:0] dimmed(input logic [7:0] c);
    int unsigned p;
    p = (c * cfg.gain + 128) >> 8;
    return (p > 255) ? 8'd255 : p[7:0];
  endfunction

  // rgb to 8-bit hsv with rounded reciprocals of 12 fraction bits
  function automatic void hsv_of(input int b, input int g, input int r,
                                 output int h, output int s, output int v);
    int mx, mn, d, num, hdiv, t;
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    v = mx;
    s = (mx == 0) ? 0 : (d * ((1044480 + mx / 2) / mx) + 2048) >> 12;
    if (d == 0) h = 0;
    else begin
      hdiv = (122880 + d / 2) / d;
      if (mx == r) num = g - b;
      else if (mx == g) num = b - r + 2 * d;
      else num = r - g + 4 * d;
      t = num * hdiv + 2048 + (1 << 20);
      h = (t >>> 12) - 256;
      if (h < 0) h += 180;
    end
  endfunction

  function automatic pixel_result_t classify(input logic [7:0] b, input logic [7:0] g,
                                             input logic [7:0] r, input logic last);
    pixel_result_t res;
    int h, s, v;
    logic in_band;
    longint unsigned q;
    hsv_of(b, g, r, h, s, v);
    in_band = (h >= cfg.lo_min && h <= cfg.lo_max) || (h >= cfg.hi_min && h <= cfg.hi_max);
    res.mark = in_band && s >= cfg.sat_min && v >= cfg.val_min;
    if (pix_cnt < FRAME_CAP) pix_cnt++;
    if (res.mark && mark_cnt < FRAME_CAP) mark_cnt++;
    res.last = last;
    res.ratio = '0;
    res.total = '0;
    if (last) begin
      res.total = mark_cnt[TOTAL_W-1:0];
      q = (longint'(mark_cnt) << 16) / pix_cnt;
      if (q > 65536) q = 65536;
      res.ratio = q[RATIO_W-1:0];
      pix_cnt = 0;
      mark_cnt = 0;
    end
    res.blue  = res.mark ? b : dimmed(b);
    res.green = res.mark ? g : dimmed(g);
    res.red   = res.mark ? r : dimmed(r);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_result_t want;
    if (!rst_ni) begin
      cfg <= '{lo_min: 8'd0, lo_max: 8'd20, hi_min: 8'd160, hi_max: 8'd180,
               sat_min: 8'd70, val_min: 8'd50, gain: 9'd77};
      pix_cnt = 0;
      mark_cnt = 0;
      fail_count = 0;
      expected_pixels.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_LO_MIN:  cfg.lo_min  <= pwdata[7:0];
          REG_LO_MAX:  cfg.lo_max  <= pwdata[7:0];
          REG_HI_MIN:  cfg.hi_min  <= pwdata[7:0];
          REG_HI_MAX:  cfg.hi_max  <= pwdata[7:0];
          REG_SAT_MIN: cfg.sat_min <= pwdata[7:0];
          REG_VAL_MIN: cfg.val_min <= pwdata[7:0];
          REG_GAIN:    cfg.gain    <= pwdata[8:0];
          default: ;
        endcase
      end
      if (!empty && pop) begin
        if (expected_pixels.size() == 0) begin
          $error("result with nothing expected");
          fail_count++;
        end else begin
          want = expected_pixels.pop_front();
          if (out_blue_o !== want.blue) begin
            $error("out_blue exp %0d got %0d", want.blue, out_blue_o); fail_count++;
          end
          if (out_green_o !== want.green) begin
            $error("out_green exp %0d got %0d", want.green, out_green_o); fail_count++;
          end
          if (out_red_o !== want.red) begin
            $error("out_red exp %0d got %0d", want.red, out_red_o); fail_count++;
          end
          if (marked_o !== want.mark) begin
            $error("marked exp %0d got %0d", want.mark, marked_o); fail_count++;
          end
          if (frame_end_o !== want.last) begin
            $error("frame_end exp %0d got %0d", want.last, frame_end_o); fail_count++;
          end
          if (marked_ratio_o !== want.ratio) begin
            $error("marked_ratio exp %0d got %0d", want.ratio, marked_ratio_o); fail_count++;
          end
          if (marked_total_o !== want.total) begin
            $error("marked_total exp %0d got %0d", want.total, marked_total_o); fail_count++;
          end
        end
      end
      if (push && !full)
        expected_pixels.push_back(classify(blue_i, green_i, red_i, last_pixel_i));
    end
  end
endmodule

/* sim/tb.sv */
module tb;
  import hrpc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;

  logic clk_i, rst_ni;
  logic push, full, empty, pop;
  logic [7:0] blue_i, green_i, red_i;
  logic last_pixel_i;
  logic [7:0] out_blue_o, out_green_o, out_red_o;
  logic marked_o, frame_end_o;
  logic [RATIO_W-1:0] marked_ratio_o;
  logic [TOTAL_W-1:0] marked_total_o;
  logic psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  int fail_count, pending_count;
  int idle_cycles = 0;
  bit pop_random;

  hsv_red_pixel_counter_unit dut (.*);

  hrpc_checker u_checker (.*);

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  // watchdog: cycles with no item moving on either side
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // gap length: half the time none, otherwise mostly short, sometimes long
  function automatic int gap_len();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 50) return 0;
    if (sel < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side stalls at random once pop_random is set
  initial begin
    int g;
    pop = 0;
    @(negedge clk_i);
    forever begin
      if (pop_random) begin
        g = gap_len();
        pop <= 0;
        repeat (g) @(negedge clk_i);
      end
      pop <= 1;
      @(negedge clk_i);
    end
  end

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1; pwrite <= 1; penable <= 0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk_i);
    penable <= 1;
    @(negedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  // one item, held until accepted, with a random gap before it when gaps is set
  task automatic send_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r,
                            input logic last, input bit gaps);
    int n;
    n = gaps ? gap_len() : 0;
    if (n > 0) begin
      push <= 0;
      repeat (n) @(negedge clk_i);
    end
    push <= 1; blue_i <= b; green_i <= g; red_i <= r; last_pixel_i <= last;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    push <= 0;
    while (pending_count != 0) @(negedge clk_i);
    // a last pixel may hold the back end for the ratio divider
    repeat (24) @(negedge clk_i);
  endtask

  task automatic random_frames(input int items);
    int sent, flen, k;
    sent = 0;
    while (sent < items) begin
      flen = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      for (k = 0; k < flen; k++) begin
        case ($urandom_range(0, 3))
          0: send_pixel(8'($urandom_range(0, 60)), 8'($urandom_range(0, 60)),
                        8'($urandom_range(120, 255)), k == flen - 1, 1);
          1: send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)), ($urandom_range(0, 19) == 0), 1);
          default: send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), k == flen - 1, 1);
        endcase
        sent++;
      end
    end
  endtask

  initial begin
    push = 0; blue_i = 0; green_i = 0; red_i = 0; last_pixel_i = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    pop_random = 0;
    rst_ni = 0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // directed: defaults, extremes, gray, black, hue ties
    send_pixel(8'd0, 8'd0, 8'd255, 0, 0);
    send_pixel(8'd0, 8'd0, 8'd0, 0, 0);
    send_pixel(8'd255, 8'd255, 8'd255, 0, 0);
    send_pixel(8'd128, 8'd128, 8'd128, 0, 0);
    send_pixel(8'd0, 8'd255, 8'd255, 0, 0);
    send_pixel(8'd255, 8'd255, 8'd0, 0, 0);
    send_pixel(8'd255, 8'd0, 8'd255, 0, 0);
    send_pixel(8'd255, 8'd0, 8'd0, 0, 0);
    send_pixel(8'd0, 8'd255, 8'd0, 0, 0);
    send_pixel(8'd10, 8'd30, 8'd200, 0, 0);
    send_pixel(8'd40, 8'd0, 8'd200, 1, 0);
    send_pixel(8'd0, 8'd0, 8'd200, 1, 0);
    send_pixel(8'd90, 8'd90, 8'd90, 1, 0);
    // sender waits until every result is back
    drain();
    pop_random = 1;

    // full gain and above, zero gain, wide and empty bands, zero and maximal thresholds
    reg_write(REG_GAIN, 32'd256);
    reg_write(REG_SAT_MIN, 32'd0);
    reg_write(REG_VAL_MIN, 32'd0);
    reg_write(REG_LO_MAX, 32'd180);
    send_pixel(8'd1, 8'd2, 8'd3, 0, 1);
    send_pixel(8'd0, 8'd0, 8'd0, 1, 1);
    drain();
    reg_write(REG_GAIN, 32'h1FF);
    reg_write(REG_LO_MIN, 32'd255);
    reg_write(REG_LO_MAX, 32'd0);
    reg_write(REG_HI_MIN, 32'd255);
    reg_write(REG_HI_MAX, 32'd255);
    reg_write(REG_SAT_MIN, 32'd255);
    reg_write(REG_VAL_MIN, 32'd255);
    send_pixel(8'd200, 8'd100, 8'd255, 0, 1);
    send_pixel(8'd255, 8'd255, 8'd255, 1, 1);
    drain();
    reg_write(REG_GAIN, 32'd0);
    reg_write(REG_HI_MIN, 32'd0);
    reg_write(REG_HI_MAX, 32'd180);
    reg_write(REG_SAT_MIN, 32'd0);
    reg_write(REG_VAL_MIN, 32'd0);
    send_pixel(8'd255, 8'd255, 8'd255, 1, 1);
    random_frames(100);
    drain();

    // back to the usual red bands, then random band edges, thresholds and gain
    reg_write(REG_LO_MIN, 32'd0);
    reg_write(REG_LO_MAX, 32'd20);
    reg_write(REG_HI_MIN, 32'd160);
    reg_write(REG_HI_MAX, 32'd180);
    reg_write(REG_SAT_MIN, 32'd70);
    reg_write(REG_VAL_MIN, 32'd50);
    reg_write(REG_GAIN, 32'd77);
    random_frames(300);
    drain();
    reg_write(REG_LO_MAX, $urandom_range(0, 40));
    reg_write(REG_HI_MIN, $urandom_range(120, 180));
    reg_write(REG_SAT_MIN, $urandom_range(0, 255));
    reg_write(REG_VAL_MIN, $urandom_range(0, 255));
    reg_write(REG_GAIN, $urandom_range(0, 511));
    random_frames(200);
    drain();

    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
